// File: rtl/sequenced_ring_slot_manager_macros.svh
// ----------------------------------------------------------------------------
// Sequenced ring slot manager assertion macros
// Shared concurrent-assertion wrappers, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RING_SLOT_MANAGER_MACROS_SVH
`define SEQUENCED_RING_SLOT_MANAGER_MACROS_SVH

// same-cycle implication
`define SRSM_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SRSM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/srsm_pkg.sv
// ----------------------------------------------------------------------------
// srsm_pkg
// Types and constants shared by the sequenced ring slot manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srsm_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int MASK_W        = 6;
	localparam int SLOT_W        = 6;
	localparam int POS_W         = 8;
	localparam int CNT_W         = 7;
	localparam logic [MASK_W-1:0] MASK_RST = 6'd63;

	typedef enum logic [1:0] {
		CMD_PUT_RES = 2'd0,
		CMD_PUT_COM = 2'd1,
		CMD_GET_RES = 2'd2,
		CMD_GET_COM = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot_index;
		logic [POS_W-1:0]  slot_pos;
	} item_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] granted_index;
		logic [POS_W-1:0]  granted_pos;
		logic [CNT_W-1:0]  element_count;
	} result_t;

	// sequence table write request
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [POS_W-1:0]  data;
	} seq_wr_t;

	// slot of a position under the effective mask
	function automatic logic [SLOT_W-1:0] slot_of(input logic [POS_W-1:0] pos,
			input logic [MASK_W-1:0] m);
		slot_of = pos[SLOT_W-1:0] & m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/srsm_seq_table.sv
// ----------------------------------------------------------------------------
// srsm_seq_table
// Per-slot sequence memory with valid bits and write forwarding; presents
// the current sequence of the put slot and the get slot every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srsm_seq_table #(
	parameter int MAX_SLOTS = srsm_pkg::MAX_SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              clr,
	input  srsm_pkg::seq_wr_t                wr,
	input  wire  [srsm_pkg::SLOT_W-1:0]      put_addr,
	input  wire  [srsm_pkg::SLOT_W-1:0]      get_addr,
	output logic [srsm_pkg::POS_W-1:0]       put_seq,
	output logic [srsm_pkg::POS_W-1:0]       get_seq
);

	localparam int AW = $clog2(MAX_SLOTS);

	logic [srsm_pkg::POS_W-1:0] mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]       vld_q;

	logic [srsm_pkg::POS_W-1:0]  put_rd_q, get_rd_q, byp_dat_q;
	logic                        put_byp_q, get_byp_q, put_vld_q, get_vld_q;
	logic [srsm_pkg::SLOT_W-1:0] put_addr_q, get_addr_q;
	logic                        put_hit, get_hit;

	assign put_hit = wr.en && (wr.addr == put_addr);
	assign get_hit = wr.en && (wr.addr == get_addr);

	always_ff @(posedge clk) begin
		if (wr.en && !clr) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		put_rd_q  <= mem[put_addr[AW-1:0]];
		get_rd_q  <= mem[get_addr[AW-1:0]];
		byp_dat_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			put_byp_q  <= 1'b0;
			get_byp_q  <= 1'b0;
			put_vld_q  <= 1'b0;
			get_vld_q  <= 1'b0;
			put_addr_q <= '0;
			get_addr_q <= '0;
		end else if (clr) begin
			vld_q      <= '0;
			put_byp_q  <= 1'b0;
			get_byp_q  <= 1'b0;
			put_vld_q  <= 1'b0;
			get_vld_q  <= 1'b0;
			put_addr_q <= put_addr;
			get_addr_q <= get_addr;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			put_byp_q  <= put_hit;
			get_byp_q  <= get_hit;
			put_vld_q  <= vld_q[put_addr[AW-1:0]];
			get_vld_q  <= vld_q[get_addr[AW-1:0]];
			put_addr_q <= put_addr;
			get_addr_q <= get_addr;
		end
	end

	// an entry never written since clear holds its own index
	always_comb begin
		if (put_byp_q) begin
			put_seq = byp_dat_q;
		end else if (put_vld_q) begin
			put_seq = put_rd_q;
		end else begin
			put_seq = {{(srsm_pkg::POS_W-srsm_pkg::SLOT_W){1'b0}}, put_addr_q};
		end
		if (get_byp_q) begin
			get_seq = byp_dat_q;
		end else if (get_vld_q) begin
			get_seq = get_rd_q;
		end else begin
			get_seq = {{(srsm_pkg::POS_W-srsm_pkg::SLOT_W){1'b0}}, get_addr_q};
		end
	end

endmodule

`default_nettype wire

// File: rtl/srsm_exec.sv
// ----------------------------------------------------------------------------
// srsm_exec
// Command execution: ring mask, put and get positions, sequence table
// update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srsm_exec #(
	parameter int MAX_SLOTS = srsm_pkg::MAX_SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wen,
	input  wire  [srsm_pkg::MASK_W-1:0]      cfg_wdata,
	input  wire                              exec,
	input  srsm_pkg::item_t                  item_s1,
	input  wire                              out_ready,
	output logic                             out_valid_q,
	output srsm_pkg::result_t                res_q
);

	localparam logic [srsm_pkg::MASK_W-1:0] LIM = srsm_pkg::MASK_W'(MAX_SLOTS - 1);

	logic [srsm_pkg::MASK_W-1:0] mask_q, m;
	logic [srsm_pkg::POS_W-1:0]  put_q, get_q, put_d, get_d, diff;
	logic [srsm_pkg::POS_W-1:0]  put_seq, get_seq;
	srsm_pkg::seq_wr_t           wr;
	srsm_pkg::result_t           res_d;
	logic [srsm_pkg::SLOT_W-1:0] commit_slot;

	assign m           = mask_q & LIM;
	assign commit_slot = item_s1.slot_index & m;

	always_comb begin
		put_d             = put_q;
		get_d             = get_q;
		wr.en             = 1'b0;
		wr.addr           = commit_slot;
		wr.data           = item_s1.slot_pos + 8'd1;
		res_d.ok          = 1'b0;
		res_d.granted_index = '0;
		res_d.granted_pos = '0;
		if (exec) begin
			case (item_s1.cmd)
				srsm_pkg::CMD_PUT_RES: begin
					if (put_seq == put_q) begin
						put_d               = put_q + 8'd1;
						res_d.ok            = 1'b1;
						res_d.granted_index = srsm_pkg::slot_of(put_q, m);
						res_d.granted_pos   = put_q;
					end
				end
				srsm_pkg::CMD_PUT_COM: begin
					wr.en    = 1'b1;
					res_d.ok = 1'b1;
				end
				srsm_pkg::CMD_GET_RES: begin
					if (get_seq == get_q + 8'd1) begin
						get_d               = get_q + 8'd1;
						res_d.ok            = 1'b1;
						res_d.granted_index = srsm_pkg::slot_of(get_q, m);
						res_d.granted_pos   = get_q;
					end
				end
				srsm_pkg::CMD_GET_COM: begin
					wr.en    = 1'b1;
					wr.data  = item_s1.slot_pos + {2'b00, m} + 8'd1;
					res_d.ok = 1'b1;
				end
				default: begin
					res_d.ok = 1'b0;
				end
			endcase
		end
		if (cfg_wen) begin
			put_d = '0;
			get_d = '0;
			wr.en = 1'b0;
		end
		// negative difference only from inconsistent commits; shown as empty
		diff                = put_d - get_d;
		res_d.element_count = diff[7] ? '0 : diff[srsm_pkg::CNT_W-1:0];
	end

	srsm_seq_table #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (cfg_wen),
		.wr       (wr),
		.put_addr (srsm_pkg::slot_of(put_d, m)),
		.get_addr (srsm_pkg::slot_of(get_d, m)),
		.put_seq  (put_seq),
		.get_seq  (get_seq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= srsm_pkg::MASK_RST;
			put_q       <= '0;
			get_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				mask_q <= cfg_wdata;
			end
			put_q <= put_d;
			get_q <= get_d;
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sequenced_ring_slot_manager.sv
// ----------------------------------------------------------------------------
// sequenced_ring_slot_manager
// Slot reserve/commit manager of a bounded ring with per-slot sequences.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries commands (put/get reserve, put/get commit with the slot and
//   position token from the reservation). m_* returns one result per
//   command: ok, granted slot and position, element count.
//   cfg_wen/cfg_wdata write the ring mask; every write resets both positions
//   and the sequence table (entry i back to i). Write only while idle.
// Timing:
//   An accepted transaction sits in the input register; once it executes,
//   its result is registered in the output register.
//   One command per cycle while m_tready is high; the sequence memory is read
//   the cycle before at the next put and get slot, in-flight write forwarded.
// Reset:
//   arst_n clears positions and table valid bits at once, mask goes to 63;
//   no clearing sweep, the block takes commands right after reset.
// Stall:
//   With m_tready low the result holds; one more command waits in the input
//   register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequenced_ring_slot_manager_macros.svh"

module sequenced_ring_slot_manager #(
	parameter int MAX_SLOTS = srsm_pkg::MAX_SLOTS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wen,
	input  wire  [5:0]  cfg_wdata,   // ring_mask
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,     // cmd[1:0], slot_index[7:2], slot_pos[15:8]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata      // ok[0], granted_index[6:1], granted_pos[14:7],
	                                 // element_count[21:15], zero fill[23:22]
);

	logic              valid_s1, exec, out_valid_q;
	srsm_pkg::item_t   item_s1;
	srsm_pkg::result_t res_q;

	assign exec     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd        <= srsm_pkg::cmd_t'(s_tdata[1:0]);
			item_s1.slot_index <= s_tdata[7:2];
			item_s1.slot_pos   <= s_tdata[15:8];
		end
	end

	srsm_exec #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.exec        (exec),
		.item_s1     (item_s1),
		.out_ready   (m_tready),
		.out_valid_q (out_valid_q),
		.res_q       (res_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.element_count, res_q.granted_pos,
		res_q.granted_index, res_q.ok};

	`SRSM_ASSERT_SAME(a_ready_when_free, !m_tvalid || m_tready, s_tready, "input stalled while output free")
	`SRSM_ASSERT_SAME(a_refusal_zero, m_tvalid && !m_tdata[0], m_tdata[14:1] == 14'd0, "refused reservation with nonzero grant")
	`SRSM_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, valid_s1, "accepted transaction not held in input register")
	`SRSM_ASSERT_NEXT(a_exec_result, exec, m_tvalid, "executed command produced no result")

endmodule

`default_nettype wire
